### hdl/bss_pkg.sv
package bss_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 32;
  localparam int FUNC_W = 3;
  localparam int POS_W = 7;
  localparam int COUNT_W = 7;

  localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  localparam logic [POS_W-1:0] POS_NONE = '1;

  typedef struct packed {
    logic load;
    logic push;
    logic pop;
    logic peek;
    logic clear;
    logic scan_start;
    logic scan_next;
    logic found;
    logic take_key;
    logic emit;
  } bss_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] op;
    logic              empty;
    logic              full;
    logic              match;
    logic              idx_zero;
    logic              out_free;
  } bss_sts_t;

  function automatic logic [POS_W-1:0] to_pos(input logic [PTR_W-1:0] idx);
    logic [PTR_W+POS_W-1:0] wide;
    wide = {{POS_W{1'b0}}, idx};
    return wide[POS_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+COUNT_W-1:0] wide;
    wide = {{COUNT_W{1'b0}}, cnt};
    return wide[COUNT_W-1:0];
  endfunction

endpackage

### hdl/bss_req_if.sv
interface bss_req_if;
  import bss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [KEY_W-1:0]  key_in;

  modport source (output valid, output func, output key_in, input ready);
  modport sink (input valid, input func, input key_in, output ready);
endinterface

### hdl/bss_rsp_if.sv
interface bss_rsp_if;
  import bss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [KEY_W-1:0]  key_out;
  logic signed [POS_W-1:0]  position;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output ok, output key_out, output position,
                  output count, input ready);
  modport sink (input valid, input ok, input key_out, input position,
                input count, output ready);
endinterface

### hdl/bss_ram.sv
module bss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/bss_ctrl.sv
module bss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bss_pkg::bss_sts_t sts,
  output bss_pkg::bss_cmd_t cmd
);
  import bss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_EMIT;
        unique case (sts.op)
          FUNC_PUSH: begin
            cmd.push = !sts.full;
          end
          FUNC_POP: begin
            if (!sts.empty) begin
              cmd.pop    = 1'b1;
              state_next = S_READ;
            end
          end
          FUNC_PEEK: begin
            if (!sts.empty) begin
              cmd.peek   = 1'b1;
              state_next = S_READ;
            end
          end
          FUNC_SEARCH: begin
            if (!sts.empty) begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          FUNC_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        cmd.take_key = 1'b1;
        state_next   = S_EMIT;
      end
      S_SCAN: begin
        // read data belongs to the current index
        if (sts.match) begin
          cmd.found  = 1'b1;
          state_next = S_EMIT;
        end else if (sts.idx_zero) begin
          state_next = S_EMIT;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/bss_dp.sv
module bss_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  bss_pkg::bss_cmd_t               cmd,
  output bss_pkg::bss_sts_t               sts,
  input  logic [bss_pkg::FUNC_W-1:0]      func,
  input  logic signed [bss_pkg::KEY_W-1:0] key_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            ok,
  output logic signed [bss_pkg::KEY_W-1:0] key_out,
  output logic signed [bss_pkg::POS_W-1:0] position,
  output logic [bss_pkg::COUNT_W-1:0]     count
);
  import bss_pkg::*;

  logic [CNT_W-1:0]  entry_count;
  logic [FUNC_W-1:0] op;
  logic [KEY_W-1:0]  key;
  logic [PTR_W-1:0]  idx;
  logic              res_ok;
  logic [KEY_W-1:0]  res_key;
  logic [POS_W-1:0]  res_pos;

  logic [CNT_W-1:0]  cnt_dec;
  logic [PTR_W-1:0]  top_idx;
  logic [PTR_W-1:0]  idx_dec;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  assign cnt_dec   = entry_count - CNT_W'(1);
  assign top_idx   = cnt_dec[PTR_W-1:0];
  assign idx_dec   = idx - PTR_W'(1);
  assign ram_re    = cmd.pop | cmd.peek | cmd.scan_start | cmd.scan_next;
  assign ram_raddr = cmd.scan_next ? idx_dec : top_idx;

  bss_ram #(
    .WIDTH(KEY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(entry_count[PTR_W-1:0]),
    .wdata(key),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.clear) begin
      entry_count <= '0;
    end else if (cmd.push) begin
      entry_count <= entry_count + CNT_W'(1);
    end else if (cmd.pop) begin
      entry_count <= cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= func;
      key <= key_in;
    end
    if (cmd.scan_start) begin
      idx <= top_idx;
    end else if (cmd.scan_next) begin
      idx <= idx_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_ok  <= 1'b0;
      res_key <= '0;
      res_pos <= POS_NONE;
    end else begin
      if (cmd.push || cmd.pop || cmd.peek || cmd.clear || cmd.found) begin
        res_ok <= 1'b1;
      end
      if (cmd.peek) begin
        res_pos <= to_pos(top_idx);
      end else if (cmd.found) begin
        res_pos <= to_pos(idx);
      end
      if (cmd.take_key) begin
        res_key <= ram_rdata;
      end
    end
  end

  // output register: a waiting result does not hold up the next transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ok       <= res_ok;
      key_out  <= res_key;
      position <= res_pos;
      count    <= to_count(entry_count);
    end
  end

  assign sts.op       = op;
  assign sts.empty    = (entry_count == '0);
  assign sts.full     = (entry_count == CNT_W'(DEPTH));
  assign sts.match    = (ram_rdata == key);
  assign sts.idx_zero = (idx == '0);
  assign sts.out_free = !out_valid || out_ready;

endmodule

### hdl/bounded_stack_with_search_core.sv
// channel | role   | payload                          | handshake
// req     | sink   | func, key_in                     | valid / ready
// rsp     | source | ok, key_out, position, count     | valid / ready
//
// Push, clear, no-ops and a failing pop, peek or empty search go from execute straight
// to emit; pop and peek pass through a key RAM read state first.
// Search steps through the key RAM one entry per cycle from the top, since the key RAM
// has a single read port.
// Reset empties the stack; the key RAM itself is not cleared.
// A result held in the output register does not block the next request; the following
// result waits until the register frees.
module bounded_stack_with_search_core (
  input logic      clk,
  input logic      rst,
  bss_req_if.sink  req,
  bss_rsp_if.source rsp
);
  import bss_pkg::*;

  bss_cmd_t cmd;
  bss_sts_t sts;
  logic     in_ready;

  assign req.ready = in_ready;

  bss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(req.valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  bss_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .func     (req.func),
    .key_in   (req.key_in),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .ok       (rsp.ok),
    .key_out  (rsp.key_out),
    .position (rsp.position),
    .count    (rsp.count)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !sts.full)
    else $error("push issued on a full stack");

  a_read_not_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop || cmd.peek || cmd.scan_start) |-> !sts.empty)
    else $error("stack read issued on an empty stack");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_next |-> !sts.idx_zero)
    else $error("scan stepped below the bottom entry");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result overwrote a pending transaction");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while another is in progress");

endmodule

### tb/bounded_stack_with_search_core_tb.sv
`timescale 1ns / 100ps

module bounded_stack_with_search_core_tb;
  import bss_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RANDOM_ITEMS = 850;
  localparam int MAX_REPORTS = 10;

  // func codes the block treats as no-ops
  localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_t;

  typedef struct {
    logic                    ok;
    logic signed [KEY_W-1:0] key;
    logic signed [POS_W-1:0] pos;
    logic [COUNT_W-1:0]      count;
  } stack_result_t;

  class stack_mirror;
    logic signed [KEY_W-1:0] keys [DEPTH];
    int depth_used;
    stack_result_t pending_results[$];
    int mismatches;
    int results_seen;
    int op_tally [8];
    int full_pushes;
    int empty_pops;
    int search_hits;
    int peak_depth;

    function new();
      depth_used = 0;
      mismatches = 0;
      results_seen = 0;
      full_pushes = 0;
      empty_pops = 0;
      search_hits = 0;
      peak_depth = 0;
      foreach (op_tally[i]) op_tally[i] = 0;
    endfunction

    function logic signed [KEY_W-1:0] stored_key();
      return keys[$urandom_range(depth_used - 1)];
    endfunction

    // apply one accepted request and queue the result it must produce
    function void note_request(logic [FUNC_W-1:0] f, logic signed [KEY_W-1:0] k);
      stack_result_t r;
      r.ok = 1'b0;
      r.key = '0;
      r.pos = POS_NONE;
      op_tally[f]++;
      case (f)
        FUNC_PUSH: begin
          if (depth_used < DEPTH) begin
            keys[depth_used] = k;
            depth_used++;
            r.ok = 1'b1;
          end else begin
            full_pushes++;
          end
        end
        FUNC_POP: begin
          if (depth_used > 0) begin
            depth_used--;
            r.ok = 1'b1;
            r.key = keys[depth_used];
          end else begin
            empty_pops++;
          end
        end
        FUNC_PEEK: begin
          if (depth_used > 0) begin
            r.ok = 1'b1;
            r.key = keys[depth_used - 1];
            r.pos = POS_W'(depth_used - 1);
          end
        end
        FUNC_SEARCH: begin
          // first match counting down from the top
          for (int i = depth_used - 1; i >= 0 && !r.ok; i--) begin
            if (keys[i] == k) begin
              r.ok = 1'b1;
              r.pos = POS_W'(i);
            end
          end
          if (r.ok) search_hits++;
        end
        FUNC_CLEAR: begin
          depth_used = 0;
          r.ok = 1'b1;
        end
        default: ;
      endcase
      r.count = COUNT_W'(depth_used);
      if (depth_used > peak_depth) peak_depth = depth_used;
      pending_results.push_back(r);
    endfunction

    function void check_response(logic ok, logic signed [KEY_W-1:0] key,
                                 logic signed [POS_W-1:0] pos, logic [COUNT_W-1:0] cnt);
      stack_result_t exp;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request outstanding: ok %0b key %0d pos %0d",
                   $time, ok, key, pos, " count %0d", cnt);
        return;
      end
      exp = pending_results.pop_front();
      if (ok !== exp.ok || key !== exp.key || pos !== exp.pos || cnt !== exp.count) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d mismatch (exp/got): ok %0b/%0b key %0d/%0d",
                   $time, results_seen, exp.ok, ok, exp.key, key,
                   " pos %0d/%0d count %0d/%0d", exp.pos, pos, exp.count, cnt);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int src_idle_pct;
  int rcv_idle_pct;
  stack_mirror mirror;

  bss_req_if req_ch();
  bss_rsp_if rsp_ch();

  bounded_stack_with_search_core DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side: check each transaction, then stall at random
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        mirror.check_response(rsp_ch.ok, rsp_ch.key_out, rsp_ch.position, rsp_ch.count);
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic signed [KEY_W-1:0] k);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.key_in <= k;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    mirror.note_request(f, k);
  endtask

  function automatic logic [FUNC_W-1:0] pick_func(input op_mix_t mix);
    int push_w, pop_w, peek_w, srch_w, r;
    case (mix)
      MIX_FILL: begin
        push_w = 80; pop_w = 5; peek_w = 5; srch_w = 8;
      end
      MIX_DRAIN: begin
        push_w = 10; pop_w = 60; peek_w = 10; srch_w = 18;
      end
      default: begin
        push_w = 35; pop_w = 25; peek_w = 15; srch_w = 23;
      end
    endcase
    r = $urandom_range(99);
    if (r < push_w) return FUNC_PUSH;
    r -= push_w;
    if (r < pop_w) return FUNC_POP;
    r -= pop_w;
    if (r < peek_w) return FUNC_PEEK;
    r -= peek_w;
    if (r < srch_w) return FUNC_SEARCH;
    // last two percent: clear, or an unused code
    if ($urandom_range(1)) return FUNC_CLEAR;
    case ($urandom_range(2))
      0: return FUNC_RSVD5;
      1: return FUNC_RSVD6;
      default: return FUNC_RSVD7;
    endcase
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key(input logic [FUNC_W-1:0] f);
    int small_v;
    if (f == FUNC_SEARCH && mirror.depth_used > 0 && $urandom_range(99) < 65)
      return mirror.stored_key();
    // small values make duplicate keys common, so the top-most match matters
    small_v = $urandom_range(7);
    case ($urandom_range(9))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2, 3, 4: return small_v - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int n_items);
    op_mix_t mix;
    int left_in_run;
    logic [FUNC_W-1:0] f;
    mix = MIX_BALANCED;
    left_in_run = 0;
    for (int i = 0; i < n_items; i++) begin
      if (left_in_run == 0) begin
        mix = op_mix_t'($urandom_range(2));
        left_in_run = $urandom_range(120, 30);
      end
      left_in_run--;
      f = pick_func(mix);
      send_op(f, pick_key(f));
    end
  endtask

  initial begin
    mirror = new();
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func <= FUNC_PUSH;
    req_ch.key_in <= '0;
    src_idle_pct = 17;
    rcv_idle_pct = 46;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty stack corner cases
    send_op(FUNC_PEEK, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_SEARCH, '0);
    // extremes, with a duplicate on top
    send_op(FUNC_PUSH, KEY_MIN);
    send_op(FUNC_PUSH, KEY_MAX);
    send_op(FUNC_PUSH, '0);
    send_op(FUNC_PUSH, -1);
    send_op(FUNC_PUSH, KEY_MAX);
    send_op(FUNC_PEEK, '0);
    send_op(FUNC_SEARCH, KEY_MAX);
    send_op(FUNC_SEARCH, KEY_MIN);
    send_op(FUNC_SEARCH, 12345);
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_PEEK, '0);
    send_op(FUNC_RSVD5, KEY_MAX);
    send_op(FUNC_RSVD6, KEY_MIN);
    send_op(FUNC_RSVD7, -1);
    send_op(FUNC_CLEAR, '0);
    send_op(FUNC_PEEK, '0);
    send_op(FUNC_SEARCH, KEY_MIN);
    send_op(FUNC_POP, '0);

    run_random(RANDOM_ITEMS / 3);
    src_idle_pct = 46;
    rcv_idle_pct = 17;
    run_random(RANDOM_ITEMS / 3);
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    req_ch.valid <= 1'b0;

    while (mirror.pending_results.size() > 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("checked %0d results: %0d push, %0d pop, %0d peek, %0d search,",
             mirror.results_seen, mirror.op_tally[FUNC_PUSH], mirror.op_tally[FUNC_POP],
             mirror.op_tally[FUNC_PEEK], mirror.op_tally[FUNC_SEARCH],
             " %0d clear, %0d no-op", mirror.op_tally[FUNC_CLEAR],
             mirror.op_tally[FUNC_RSVD5] + mirror.op_tally[FUNC_RSVD6]
             + mirror.op_tally[FUNC_RSVD7]);
    $display("peak depth %0d, %0d pushes when full, %0d pops when empty, %0d search hits",
             mirror.peak_depth, mirror.full_pushes, mirror.empty_pops, mirror.search_hits);
    if (mirror.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop in case a handshake never completes
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### bounded_stack_with_search_core.f
hdl/bss_pkg.sv
hdl/bss_req_if.sv
hdl/bss_rsp_if.sv
hdl/bss_ram.sv
hdl/bss_ctrl.sv
hdl/bss_dp.sv
hdl/bounded_stack_with_search_core.sv
tb/bounded_stack_with_search_core_tb.sv
